// File: rtl/core/sphm_pkg.sv
package sphm_pkg;

    localparam int POS_W     = 24;
    localparam int NORM_W    = 16;
    localparam int MAT_W     = 16;
    localparam int TEX_W     = 16;
    localparam int CFG_W     = 48;
    localparam int CFG_IDX_W = 3;

    localparam int E12_W  = 30;
    localparam int N16_W  = 26;
    localparam int L2_W   = 60;
    localparam int LEN_W  = L2_W / 2;
    localparam int UNUM_W = 46;
    localparam int UQ_W   = 17;
    localparam int R_W    = 32;
    localparam int Q_W    = 64;
    localparam int H_W    = Q_W / 2;
    localparam int CNUM_W = 46;
    localparam int CQ_W   = 16;

    localparam logic [TEX_W-1:0] TEX_HALF = 16'h8000;

    localparam logic [CFG_W-1:0] ROW_X_RST = 48'h0000_0000_1000;
    localparam logic [CFG_W-1:0] ROW_Y_RST = 48'h0000_1000_0000;
    localparam logic [CFG_W-1:0] ROW_Z_RST = 48'h1000_0000_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROT_X   = 3'd0,
        CFG_ROT_Y   = 3'd1,
        CFG_ROT_Z   = 3'd2,
        CFG_SHIFT_X = 3'd3,
        CFG_SHIFT_Y = 3'd4,
        CFG_SHIFT_Z = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [2:0][E12_W-1:0] e12;
        logic [2:0][N16_W-1:0] n16;
        logic                  zero;
    } t_len_side;

    typedef struct packed {
        logic [2:0]            neg;
        logic [2:0][N16_W-1:0] n16;
        logic                  zero;
    } t_udiv_side;

    typedef struct packed {
        logic [1:0][R_W-1:0] r;
        logic                zero;
    } t_h_side;

    typedef struct packed {
        logic [1:0] neg;
        logic       degen;
    } t_cdiv_side;

endpackage

// File: rtl/core/sphm_if.sv
interface sphm_vtx_if;
    import sphm_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [POS_W-1:0]   pos_x;
    logic signed [POS_W-1:0]   pos_y;
    logic signed [POS_W-1:0]   pos_z;
    logic signed [NORM_W-1:0]  norm_x;
    logic signed [NORM_W-1:0]  norm_y;
    logic signed [NORM_W-1:0]  norm_z;

    modport source (output valid, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, input ready);
    modport sink   (input valid, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, output ready);
endinterface

interface sphm_tex_if;
    import sphm_pkg::*;

    logic              valid;
    logic              ready;
    logic [TEX_W-1:0]  tex_s;
    logic [TEX_W-1:0]  tex_t;
    logic              degenerate;

    modport source (output valid, tex_s, tex_t, degenerate, input ready);
    modport sink   (input valid, tex_s, tex_t, degenerate, output ready);
endinterface

// File: rtl/core/sphm_isqrt.sv
module sphm_isqrt #(
    parameter int IN_W   = 64,
    parameter int SIDE_W = 1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  logic [IN_W-1:0]     i_x,
    input  logic [SIDE_W-1:0]   i_side,
    output logic                o_valid,
    output logic [IN_W/2-1:0]   o_root,
    output logic [SIDE_W-1:0]   o_side
);
    localparam int ROOT_W = IN_W / 2;
    localparam int REM_W  = ROOT_W + 2;

    logic              w_v    [0:ROOT_W];
    logic [IN_W-1:0]   w_x    [0:ROOT_W];
    logic [REM_W-1:0]  w_rem  [0:ROOT_W];
    logic [ROOT_W-1:0] w_root [0:ROOT_W];
    logic [SIDE_W-1:0] w_side [0:ROOT_W];

    assign w_v[0]    = i_valid;
    assign w_x[0]    = i_x;
    assign w_rem[0]  = '0;
    assign w_root[0] = '0;
    assign w_side[0] = i_side;

    for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
        logic [REM_W-1:0]  rem_sh;
        logic [REM_W-1:0]  trial;
        logic              fit;
        logic [REM_W-1:0]  n_rem;
        logic [ROOT_W-1:0] n_root;
        logic              r_v;
        logic [IN_W-1:0]   r_x;
        logic [REM_W-1:0]  r_rem;
        logic [ROOT_W-1:0] r_root;
        logic [SIDE_W-1:0] r_side;

        always_comb begin
            rem_sh = {w_rem[k][ROOT_W-1:0], w_x[k][IN_W-1 -: 2]};
            trial  = {w_root[k], 2'b01};
            fit    = (rem_sh >= trial);
            n_rem  = fit ? (rem_sh - trial) : rem_sh;
            n_root = {w_root[k][ROOT_W-2:0], fit};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else if (i_en) begin
                r_v <= w_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x    <= {w_x[k][IN_W-3:0], 2'b00};
                r_rem  <= n_rem;
                r_root <= n_root;
                r_side <= w_side[k];
            end
        end

        assign w_v[k+1]    = r_v;
        assign w_x[k+1]    = r_x;
        assign w_rem[k+1]  = r_rem;
        assign w_root[k+1] = r_root;
        assign w_side[k+1] = r_side;
    end

    assign o_valid = w_v[ROOT_W];
    assign o_root  = w_root[ROOT_W];
    assign o_side  = w_side[ROOT_W];
endmodule

// File: rtl/core/sphm_div.sv
module sphm_div #(
    parameter int LANES  = 1,
    parameter int NUM_W  = 46,
    parameter int DEN_W  = 32,
    parameter int QUO_W  = 16,
    parameter int SIDE_W = 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic [LANES-1:0][NUM_W-1:0]   i_num,
    input  logic [DEN_W-1:0]              i_den,
    input  logic [SIDE_W-1:0]             i_side,
    output logic                          o_valid,
    output logic [LANES-1:0][QUO_W-1:0]   o_quo,
    output logic [SIDE_W-1:0]             o_side
);
    logic                          w_v    [0:QUO_W];
    logic [DEN_W-1:0]              w_den  [0:QUO_W];
    logic [LANES-1:0][DEN_W-1:0]   w_rem  [0:QUO_W];
    logic [LANES-1:0][QUO_W-1:0]   w_lo   [0:QUO_W];
    logic [LANES-1:0][QUO_W-1:0]   w_quo  [0:QUO_W];
    logic [SIDE_W-1:0]             w_side [0:QUO_W];

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            w_rem[0][l] = DEN_W'(i_num[l][NUM_W-1:QUO_W]);
            w_lo[0][l]  = i_num[l][QUO_W-1:0];
        end
    end

    assign w_v[0]    = i_valid;
    assign w_den[0]  = i_den;
    assign w_quo[0]  = '0;
    assign w_side[0] = i_side;

    for (genvar k = 0; k < QUO_W; k++) begin : g_stage
        logic [LANES-1:0][DEN_W:0]     rem_sh;
        logic [LANES-1:0][DEN_W:0]     diff;
        logic [LANES-1:0]              fit;
        logic [LANES-1:0][DEN_W-1:0]   n_rem;
        logic [LANES-1:0][QUO_W-1:0]   n_lo;
        logic [LANES-1:0][QUO_W-1:0]   n_quo;
        logic                          r_v;
        logic [DEN_W-1:0]              r_den;
        logic [LANES-1:0][DEN_W-1:0]   r_rem;
        logic [LANES-1:0][QUO_W-1:0]   r_lo;
        logic [LANES-1:0][QUO_W-1:0]   r_quo;
        logic [SIDE_W-1:0]             r_side;

        always_comb begin
            for (int l = 0; l < LANES; l++) begin
                rem_sh[l] = {w_rem[k][l], w_lo[k][l][QUO_W-1]};
                diff[l]   = rem_sh[l] - {1'b0, w_den[k]};
                fit[l]    = (rem_sh[l] >= {1'b0, w_den[k]});
                n_rem[l]  = fit[l] ? diff[l][DEN_W-1:0] : rem_sh[l][DEN_W-1:0];
                n_lo[l]   = {w_lo[k][l][QUO_W-2:0], 1'b0};
                n_quo[l]  = {w_quo[k][l][QUO_W-2:0], fit[l]};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else if (i_en) begin
                r_v <= w_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_den  <= w_den[k];
                r_rem  <= n_rem;
                r_lo   <= n_lo;
                r_quo  <= n_quo;
                r_side <= w_side[k];
            end
        end

        assign w_v[k+1]    = r_v;
        assign w_den[k+1]  = r_den;
        assign w_rem[k+1]  = r_rem;
        assign w_lo[k+1]   = r_lo;
        assign w_quo[k+1]  = r_quo;
        assign w_side[k+1] = r_side;
    end

    assign o_valid = w_v[QUO_W];
    assign o_quo   = w_quo[QUO_W];
    assign o_side  = w_side[QUO_W];
endmodule

// File: rtl/core/sphere_map_texcoord_gen.sv
// Channel  | Dir | Payload                                         | Accepted when
// i_vtx    | in  | pos_x/y/z (s24 Q11.12), norm_x/y/z (s16 Q3.12)  | valid & ready
// o_tex    | out | tex_s, tex_t (u16 Q0.16), degenerate            | valid & ready
// i_cfg_*  | in  | register index, 48-bit data                     | i_cfg_we
//
// One vertex per cycle while the pipeline is not held; the path runs through the two square-root pipelines
// (30 and 32 stages) and the two divider pipelines (17 and 16 stages).
// Synchronous active-low reset clears the valid bits and loads the identity matrix.
// The pipeline holds only when its last stage and the output register are both full
// and the output is stalled; nothing is dropped or repeated.
module sphere_map_texcoord_gen (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [sphm_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [sphm_pkg::CFG_W-1:0]     i_cfg_data,
    sphm_vtx_if.sink                       i_vtx,
    sphm_tex_if.source                     o_tex
);
    import sphm_pkg::*;

    localparam logic signed [42:0] SAT_HI = 43'sd2147483647;
    localparam logic signed [42:0] SAT_LO = -43'sd2147483647;
    localparam logic signed [42:0] W_ONE  = 43'sd65536;

    function automatic logic signed [R_W-1:0] sat_r(input logic signed [42:0] v);
        logic signed [R_W-1:0] res;
        if (v > SAT_HI) begin
            res = 32'sh7fffffff;
        end else if (v < SAT_LO) begin
            res = 32'sh80000001;
        end else begin
            res = v[R_W-1:0];
        end
        return res;
    endfunction

    logic [CFG_W-1:0]        r_row   [3];
    logic signed [POS_W-1:0] r_shift [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row[0]   <= ROW_X_RST;
            r_row[1]   <= ROW_Y_RST;
            r_row[2]   <= ROW_Z_RST;
            r_shift[0] <= '0;
            r_shift[1] <= '0;
            r_shift[2] <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_ROT_X:   r_row[0]   <= i_cfg_data;
                CFG_ROT_Y:   r_row[1]   <= i_cfg_data;
                CFG_ROT_Z:   r_row[2]   <= i_cfg_data;
                CFG_SHIFT_X: r_shift[0] <= i_cfg_data[POS_W-1:0];
                CFG_SHIFT_Y: r_shift[1] <= i_cfg_data[POS_W-1:0];
                CFG_SHIFT_Z: r_shift[2] <= i_cfg_data[POS_W-1:0];
                default: ;
            endcase
        end
    end

    logic en;
    logic r_s12_v;
    logic r_out_v;

    assign en          = !r_s12_v || !r_out_v || o_tex.ready;
    assign i_vtx.ready = en;

    logic signed [MAT_W-1:0]  mat     [3][3];
    logic signed [POS_W-1:0]  in_pos  [3];
    logic signed [NORM_W-1:0] in_norm [3];

    assign in_pos[0]  = i_vtx.pos_x;
    assign in_pos[1]  = i_vtx.pos_y;
    assign in_pos[2]  = i_vtx.pos_z;
    assign in_norm[0] = i_vtx.norm_x;
    assign in_norm[1] = i_vtx.norm_y;
    assign in_norm[2] = i_vtx.norm_z;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                mat[i][j] = r_row[i][MAT_W*j +: MAT_W];
            end
        end
    end

    // stage 1: matrix products
    logic              r_s1_v;
    logic signed [39:0] r_s1_pe [3][3];
    logic signed [31:0] r_s1_pn [3][3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (en) begin
            r_s1_v <= i_vtx.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_s1_pe[i][j] <= mat[i][j] * in_pos[j];
                    r_s1_pn[i][j] <= mat[i][j] * in_norm[j];
                end
            end
        end
    end

    // stage 2: row sums, translation, rescale
    logic signed [41:0] e_sum [3];
    logic signed [33:0] n_sum [3];
    logic                    r_s2_v;
    logic signed [E12_W-1:0] r_s2_e12 [3];
    logic signed [N16_W-1:0] r_s2_n16 [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            e_sum[i] = r_s1_pe[i][0] + r_s1_pe[i][1] + r_s1_pe[i][2]
                     + $signed({r_shift[i], 12'b0});
            n_sum[i] = r_s1_pn[i][0] + r_s1_pn[i][1] + r_s1_pn[i][2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else if (en) begin
            r_s2_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_s2_e12[i] <= e_sum[i][41:12];
                r_s2_n16[i] <= n_sum[i][33:8];
            end
        end
    end

    // stage 3: squares of the eye position
    logic                    r_s3_v;
    logic signed [L2_W-1:0]  r_s3_sq  [3];
    logic signed [E12_W-1:0] r_s3_e12 [3];
    logic signed [N16_W-1:0] r_s3_n16 [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_v <= 1'b0;
        end else if (en) begin
            r_s3_v <= r_s2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_s3_sq[i]  <= r_s2_e12[i] * r_s2_e12[i];
                r_s3_e12[i] <= r_s2_e12[i];
                r_s3_n16[i] <= r_s2_n16[i];
            end
        end
    end

    // stage 4: squared length
    logic                    r_s4_v;
    logic [L2_W-1:0]         r_s4_l2;
    logic signed [E12_W-1:0] r_s4_e12 [3];
    logic signed [N16_W-1:0] r_s4_n16 [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_v <= 1'b0;
        end else if (en) begin
            r_s4_v <= r_s3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s4_l2 <= $unsigned(r_s3_sq[0] + r_s3_sq[1] + r_s3_sq[2]);
            for (int i = 0; i < 3; i++) begin
                r_s4_e12[i] <= r_s3_e12[i];
                r_s4_n16[i] <= r_s3_n16[i];
            end
        end
    end

    // eye length
    t_len_side         len_si;
    t_len_side         len_so;
    logic              len_v;
    logic [LEN_W-1:0]  len;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            len_si.e12[i] = r_s4_e12[i];
            len_si.n16[i] = r_s4_n16[i];
        end
        len_si.zero = (r_s4_l2 == '0);
    end

    sphm_isqrt #(
        .IN_W   (L2_W),
        .SIDE_W ($bits(t_len_side))
    ) u_len_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_s4_v),
        .i_x     (r_s4_l2),
        .i_side  (len_si),
        .o_valid (len_v),
        .o_root  (len),
        .o_side  (len_so)
    );

    // unit eye vector
    logic [2:0][UNUM_W-1:0] u_num;
    logic [E12_W-1:0]       e_mag [3];
    t_udiv_side             ud_si;
    t_udiv_side             ud_so;
    logic                   ud_v;
    logic [2:0][UQ_W-1:0]   ud_q;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            e_mag[i]     = len_so.e12[i][E12_W-1] ? (~len_so.e12[i] + 1'b1) : len_so.e12[i];
            u_num[i]     = {e_mag[i], 16'b0};
            ud_si.neg[i] = len_so.e12[i][E12_W-1];
            ud_si.n16[i] = len_so.n16[i];
        end
        ud_si.zero = len_so.zero;
    end

    sphm_div #(
        .LANES  (3),
        .NUM_W  (UNUM_W),
        .DEN_W  (LEN_W),
        .QUO_W  (UQ_W),
        .SIDE_W ($bits(t_udiv_side))
    ) u_eye_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (len_v),
        .i_num   (u_num),
        .i_den   (len),
        .i_side  (ud_si),
        .o_valid (ud_v),
        .o_quo   (ud_q),
        .o_side  (ud_so)
    );

    // stage 5: signed u and u*n
    logic signed [17:0]      u_val [3];
    logic                    r_s5_v;
    logic                    r_s5_zero;
    logic signed [43:0]      r_s5_un  [3];
    logic signed [17:0]      r_s5_u   [3];
    logic signed [N16_W-1:0] r_s5_n16 [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            u_val[i] = ud_so.neg[i] ? -$signed({1'b0, ud_q[i]}) : $signed({1'b0, ud_q[i]});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s5_v <= 1'b0;
        end else if (en) begin
            r_s5_v <= ud_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s5_zero <= ud_so.zero;
            for (int i = 0; i < 3; i++) begin
                r_s5_un[i]  <= u_val[i] * $signed(ud_so.n16[i]);
                r_s5_u[i]   <= u_val[i];
                r_s5_n16[i] <= ud_so.n16[i];
            end
        end
    end

    // stage 6: dot product
    logic signed [45:0]      dot;
    logic                    r_s6_v;
    logic                    r_s6_zero;
    logic signed [29:0]      r_s6_d;
    logic signed [17:0]      r_s6_u   [3];
    logic signed [N16_W-1:0] r_s6_n16 [3];

    assign dot = r_s5_un[0] + r_s5_un[1] + r_s5_un[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s6_v <= 1'b0;
        end else if (en) begin
            r_s6_v <= r_s5_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s6_zero <= r_s5_zero;
            r_s6_d    <= dot[45:16];
            for (int i = 0; i < 3; i++) begin
                r_s6_u[i]   <= r_s5_u[i];
                r_s6_n16[i] <= r_s5_n16[i];
            end
        end
    end

    // stage 7: d*n
    logic               r_s7_v;
    logic               r_s7_zero;
    logic signed [55:0] r_s7_pm [3];
    logic signed [17:0] r_s7_u  [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s7_v <= 1'b0;
        end else if (en) begin
            r_s7_v <= r_s6_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s7_zero <= r_s6_zero;
            for (int i = 0; i < 3; i++) begin
                r_s7_pm[i] <= r_s6_d * r_s6_n16[i];
                r_s7_u[i]  <= r_s6_u[i];
            end
        end
    end

    // stage 8: reflection and saturation
    logic signed [41:0]    refl [3];
    logic signed [42:0]    wz;
    logic                  r_s8_v;
    logic                  r_s8_zero;
    logic signed [R_W-1:0] r_s8_rx;
    logic signed [R_W-1:0] r_s8_ry;
    logic signed [R_W-1:0] r_s8_w;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            refl[i] = r_s7_u[i] - $signed(r_s7_pm[i][55:15]);
        end
        wz = refl[2] + W_ONE;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s8_v <= 1'b0;
        end else if (en) begin
            r_s8_v <= r_s7_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s8_zero <= r_s7_zero;
            r_s8_rx   <= sat_r(43'(refl[0]));
            r_s8_ry   <= sat_r(43'(refl[1]));
            r_s8_w    <= sat_r(wz);
        end
    end

    // stage 9: squares of the reflection
    logic                  r_s9_v;
    logic                  r_s9_zero;
    logic signed [Q_W-1:0] r_s9_sq [3];
    logic signed [R_W-1:0] r_s9_rx;
    logic signed [R_W-1:0] r_s9_ry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s9_v <= 1'b0;
        end else if (en) begin
            r_s9_v <= r_s8_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s9_zero  <= r_s8_zero;
            r_s9_sq[0] <= r_s8_rx * r_s8_rx;
            r_s9_sq[1] <= r_s8_ry * r_s8_ry;
            r_s9_sq[2] <= r_s8_w * r_s8_w;
            r_s9_rx    <= r_s8_rx;
            r_s9_ry    <= r_s8_ry;
        end
    end

    // stage 10: squared length of the reflection
    logic                  r_s10_v;
    logic                  r_s10_zero;
    logic [Q_W-1:0]        r_s10_q;
    logic signed [R_W-1:0] r_s10_rx;
    logic signed [R_W-1:0] r_s10_ry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s10_v <= 1'b0;
        end else if (en) begin
            r_s10_v <= r_s9_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s10_zero <= r_s9_zero;
            r_s10_q    <= $unsigned(r_s9_sq[0]) + $unsigned(r_s9_sq[1])
                        + $unsigned(r_s9_sq[2]);
            r_s10_rx   <= r_s9_rx;
            r_s10_ry   <= r_s9_ry;
        end
    end

    // half of m
    t_h_side         h_si;
    t_h_side         h_so;
    logic            h_v;
    logic [H_W-1:0]  h_len;

    always_comb begin
        h_si.r[0] = r_s10_rx;
        h_si.r[1] = r_s10_ry;
        h_si.zero = r_s10_zero;
    end

    sphm_isqrt #(
        .IN_W   (Q_W),
        .SIDE_W ($bits(t_h_side))
    ) u_h_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_s10_v),
        .i_x     (r_s10_q),
        .i_side  (h_si),
        .o_valid (h_v),
        .o_root  (h_len),
        .o_side  (h_so)
    );

    // coordinate quotients
    logic [R_W-1:0]         r_mag [2];
    logic [1:0][CNUM_W-1:0] c_num;
    t_cdiv_side             cd_si;
    t_cdiv_side             cd_so;
    logic                   cd_v;
    logic [1:0][CQ_W-1:0]   cd_q;

    always_comb begin
        for (int i = 0; i < 2; i++) begin
            r_mag[i]     = h_so.r[i][R_W-1] ? (~h_so.r[i] + 1'b1) : h_so.r[i];
            c_num[i]     = {r_mag[i][R_W-2:0], 15'b0};
            cd_si.neg[i] = h_so.r[i][R_W-1];
        end
        cd_si.degen = h_so.zero || (h_len == '0);
    end

    sphm_div #(
        .LANES  (2),
        .NUM_W  (CNUM_W),
        .DEN_W  (H_W),
        .QUO_W  (CQ_W),
        .SIDE_W ($bits(t_cdiv_side))
    ) u_coord_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (h_v),
        .i_num   (c_num),
        .i_den   (h_len),
        .i_side  (cd_si),
        .o_valid (cd_v),
        .o_quo   (cd_q),
        .o_side  (cd_so)
    );

    // stage 12: offset, clamp, degenerate override
    logic [TEX_W:0]   c_sum [2];
    logic [TEX_W-1:0] c_val [2];
    logic [TEX_W-1:0] r_s12_s;
    logic [TEX_W-1:0] r_s12_t;
    logic             r_s12_degen;

    always_comb begin
        for (int i = 0; i < 2; i++) begin
            c_sum[i] = cd_so.neg[i] ? ({1'b0, TEX_HALF} - {1'b0, cd_q[i]})
                                    : ({1'b0, TEX_HALF} + {1'b0, cd_q[i]});
            if (cd_so.degen) begin
                c_val[i] = TEX_HALF;
            end else if (c_sum[i][TEX_W]) begin
                c_val[i] = '1;
            end else begin
                c_val[i] = c_sum[i][TEX_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s12_v <= 1'b0;
        end else if (en) begin
            r_s12_v <= cd_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s12_s     <= c_val[0];
            r_s12_t     <= c_val[1];
            r_s12_degen <= cd_so.degen;
        end
    end

    // output register
    logic [TEX_W-1:0] r_out_s;
    logic [TEX_W-1:0] r_out_t;
    logic             r_out_degen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (!r_out_v || o_tex.ready) begin
            r_out_v <= r_s12_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_v || o_tex.ready) begin
            r_out_s     <= r_s12_s;
            r_out_t     <= r_s12_t;
            r_out_degen <= r_s12_degen;
        end
    end

    assign o_tex.valid      = r_out_v;
    assign o_tex.tex_s      = r_out_s;
    assign o_tex.tex_t      = r_out_t;
    assign o_tex.degenerate = r_out_degen;
endmodule

// File: rtl/core/sphm_checker.sv
module sphm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    sphm_vtx_if.sink   i_vtx,
    sphm_tex_if.source o_tex
);
    import sphm_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_tex.valid && !o_tex.ready |=> o_tex.valid)
        else $error("result request dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_tex.valid && !o_tex.ready |=>
            $stable(o_tex.tex_s) && $stable(o_tex.tex_t) && $stable(o_tex.degenerate))
        else $error("result payload changed while stalled");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_tex.valid |-> i_vtx.ready)
        else $error("vertex request refused with empty output");

    a_degen_half: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_tex.valid && o_tex.degenerate |->
            o_tex.tex_s == TEX_HALF && o_tex.tex_t == TEX_HALF)
        else $error("degenerate result not centered");
endmodule

bind sphere_map_texcoord_gen sphm_checker u_sphm_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_vtx   (i_vtx),
    .o_tex   (o_tex)
);
